// ===== sv/kdmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdmb_pkg
// Types, register codes and constants shared by the kernel density block.
// ----------------------------------------------------------------------------
package kdmb_pkg;

    localparam int DEF_MAX_DISTANCES  = 1024;
    localparam int DEF_MAX_BANDWIDTHS = 6;
    localparam int NUM_BW_REGS        = 6;
    localparam int PADDR_W            = 5;
    localparam int SUM_W              = 27;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Register indexes (word address of the configuration port).
    localparam logic [2:0] REG_KERNEL_SELECT   = 3'd0;
    localparam logic [2:0] REG_BANDWIDTH_COUNT = 3'd1;
    localparam logic [2:0] REG_BANDWIDTH_A     = 3'd2;

    // Kernel codes; any other code is the quartic kernel.
    localparam logic [1:0] KERNEL_TRIANGULAR   = 2'd0;
    localparam logic [1:0] KERNEL_EPANECHNIKOV = 2'd1;

    typedef struct packed {
        logic [15:0] distance;
        logic        has_distance;
        logic        end_of_cell;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       bandwidth_index;
        logic [SUM_W-1:0] kernel_sum;
        logic             last_result;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BSQ,
        ST_BQUAD,
        ST_READ,
        ST_DATA,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUTPUT
    } state_t;

endpackage

// ===== sv/kdmb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdmb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kdmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== sv/kdmb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdmb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kdmb_div #(
    parameter int NUM_W = 97,
    parameter int DEN_W = 64,
    localparam int CW   = $clog2(NUM_W + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done_reg,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] rem_reg, rem_next, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic [DEN_W:0]   rem_shift;
    logic             ge;

    always_comb begin
        rem_shift = {rem_reg, work_reg[NUM_W-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_next  = ge ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
        work_next = {work_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (run_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = work_reg;

endmodule

// ===== sv/kernel_density_multi_bandwidth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_density_multi_bandwidth
// Kernel density sums of one query cell over up to six bandwidths.
// ----------------------------------------------------------------------------
// Usage: neighbor distances come in on the s_ channel, one item per accepted
// handshake, and are written into a distance store, so loading runs at one
// item per cycle while the block is idle. Items that arrive with the store
// full lose their distance. The item that carries end_of_cell starts the
// pass: for each bandwidth in use the sequencer squares the bandwidth, sweeps
// the store through one shared multiplier, and then divides a nonzero
// weighted sum by the kernel's normalizer in a restoring divider that takes
// one quotient bit per cycle. The numerator width NUM_W is 92 bits for 1024
// entries. Each result waits for m_ready. Results leave on the m_ channel
// in bandwidth order, the final one carrying last_result. s_ready is low for
// the whole pass.
// A stalled receiver simply holds the block in its output state; the result
// stays on m_data unchanged until taken. After the last result the store is
// empty again. Reset (aresetn low, synchronous) empties the store, aborts
// any pass and restores the register defaults; the store itself is not
// cleared, only its fill count.
// Registers (APB, word addresses): 0 kernel_select, 1 bandwidth_count,
// 2..7 bandwidth_a..bandwidth_f.
// ----------------------------------------------------------------------------
module kernel_density_multi_bandwidth
    import kdmb_pkg::*;
#(
    parameter int MAX_DISTANCES  = DEF_MAX_DISTANCES,
    parameter int MAX_BANDWIDTHS = DEF_MAX_BANDWIDTHS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    localparam int CNTW  = $clog2(MAX_DISTANCES + 1);
    localparam int AW    = (MAX_DISTANCES > 1) ? $clog2(MAX_DISTANCES) : 1;
    localparam int ACC_W = 64 + CNTW;
    localparam int NUM_W = ACC_W + 17;

    // Configuration registers.
    logic [1:0]  kernel_select_reg;
    logic [2:0]  bandwidth_count_reg;
    logic [15:0] bw_reg [NUM_BW_REGS];
    logic [2:0]  reg_index;
    logic        cfg_we;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_we    = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_select_reg   <= KERNEL_TRIANGULAR;
            bandwidth_count_reg <= 3'd1;
            for (int i = 0; i < NUM_BW_REGS; i++) begin
                bw_reg[i] <= 16'd256;
            end
        end else if (cfg_we) begin
            case (reg_index)
                REG_KERNEL_SELECT:   kernel_select_reg   <= pwdata[1:0];
                REG_BANDWIDTH_COUNT: bandwidth_count_reg <= pwdata[2:0];
                default: begin
                    bw_reg[3'(reg_index - REG_BANDWIDTH_A)] <= pwdata[15:0];
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_KERNEL_SELECT:   prdata = {30'd0, kernel_select_reg};
            REG_BANDWIDTH_COUNT: prdata = {29'd0, bandwidth_count_reg};
            default:             prdata = {16'd0, bw_reg[3'(reg_index - REG_BANDWIDTH_A)]};
        endcase
    end

    // Number of bandwidths in use, clamped into range.
    logic [2:0] bw_used;
    always_comb begin
        if (bandwidth_count_reg == 3'd0) begin
            bw_used = 3'd1;
        end else if (bandwidth_count_reg > 3'(MAX_BANDWIDTHS)) begin
            bw_used = 3'(MAX_BANDWIDTHS);
        end else begin
            bw_used = bandwidth_count_reg;
        end
    end

    // Sequencer and datapath registers.
    state_t            state_reg, state_next;
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   idx_reg;
    logic [2:0]        k_reg;
    logic [31:0]       b2_reg;
    logic [63:0]       b4_reg;
    logic [63:0]       prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              s_fire, m_fire;
    logic [15:0]       bw;
    logic [15:0]       rd_dist;
    logic              is_tri, is_epa;
    logic              in_range, last_elem, last_bw;
    logic [31:0]       wdiff;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [63:0]       den;
    logic [NUM_W-1:0]  num;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [SUM_W-1:0]  sum_sat;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign m_fire    = m_valid_reg && m_ready;

    assign bw        = bw_reg[k_reg];
    assign is_tri    = (kernel_select_reg == KERNEL_TRIANGULAR);
    assign is_epa    = (kernel_select_reg == KERNEL_EPANECHNIKOV);
    assign in_range  = rd_dist < bw;
    assign last_elem = (idx_reg == CNTW'(count_reg - 1'b1));
    assign last_bw   = (k_reg == 3'(bw_used - 3'd1));
    assign wdiff     = b2_reg - prod_reg[31:0];
    assign ram_we    = s_fire && s_data.has_distance && (count_reg < CNTW'(MAX_DISTANCES));
    assign ram_raddr = idx_reg[AW-1:0];

    kdmb_ram #(
        .WIDTH (16),
        .DEPTH (MAX_DISTANCES)
    ) u_store (
        .aclk      (aclk),
        .we        (ram_we),
        .waddr     (count_reg[AW-1:0]),
        .wdata     (s_data.distance),
        .raddr     (ram_raddr),
        .rdata_reg (rd_dist)
    );

    // The one shared multiplier; its operands follow the state.
    always_comb begin
        case (state_reg)
            ST_BSQ:   begin mul_a = {16'd0, bw};      mul_b = {16'd0, bw};      end
            ST_BQUAD: begin mul_a = b2_reg;           mul_b = b2_reg;           end
            ST_DATA:  begin mul_a = {16'd0, rd_dist}; mul_b = {16'd0, rd_dist}; end
            default:  begin mul_a = wdiff;            mul_b = wdiff;            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Normalizer and rounded numerator: (acc * 2^16 + den/2) / den.
    always_comb begin
        if (is_tri) begin
            den = {48'd0, bw};
        end else if (is_epa) begin
            den = {32'd0, b2_reg};
        end else begin
            den = b4_reg;
        end
        num = {1'b0, acc_reg, 16'd0} + NUM_W'(den >> 1);
    end

    assign div_start = (state_reg == ST_DIV_START) && (acc_reg != '0);

    kdmb_div #(
        .NUM_W (NUM_W),
        .DEN_W (64)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (num),
        .den      (den),
        .done_reg (div_done),
        .quot     (div_quot)
    );

    assign sum_sat = (|div_quot[NUM_W-1:SUM_W]) ? SUM_MAX : div_quot[SUM_W-1:0];

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.end_of_cell) begin
                    state_next = ST_BSQ;
                end
            end
            ST_BSQ:   state_next = ST_BQUAD;
            ST_BQUAD: state_next = (count_reg == '0) ? ST_DIV_START : ST_READ;
            ST_READ:  state_next = ST_DATA;
            ST_DATA: begin
                if (!in_range || is_tri) begin
                    state_next = last_elem ? ST_DIV_START : ST_READ;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (is_epa) begin
                    state_next = last_elem ? ST_DIV_START : ST_READ;
                end else begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:     state_next = last_elem ? ST_DIV_START : ST_READ;
            ST_DIV_START: state_next = (acc_reg == '0) ? ST_OUTPUT : ST_DIV_WAIT;
            ST_DIV_WAIT:  state_next = div_done ? ST_OUTPUT : ST_DIV_WAIT;
            ST_OUTPUT: begin
                if (m_fire) begin
                    state_next = last_bw ? ST_IDLE : ST_BSQ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                count_reg <= count_reg + 1'b1;
            end
            case (state_reg)
                ST_IDLE: k_reg <= '0;
                ST_BSQ:  idx_reg <= '0;
                ST_DATA: begin
                    if (!in_range || is_tri) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SQUARE: begin
                    if (is_epa) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_ACCUM:     idx_reg <= idx_reg + 1'b1;
                ST_DIV_START: if (acc_reg == '0) m_valid_reg <= 1'b1;
                ST_DIV_WAIT:  if (div_done) m_valid_reg <= 1'b1;
                ST_OUTPUT: begin
                    if (m_fire) begin
                        m_valid_reg <= 1'b0;
                        k_reg       <= k_reg + 3'd1;
                        if (last_bw) begin
                            count_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_BSQ: begin
                b2_reg  <= mul_p[31:0];
                acc_reg <= '0;
            end
            ST_BQUAD: b4_reg <= mul_p;
            ST_DATA: begin
                prod_reg <= mul_p;
                if (in_range && is_tri) begin
                    acc_reg <= acc_reg + ACC_W'(bw - rd_dist);
                end
            end
            ST_SQUARE: begin
                prod_reg <= mul_p;
                if (is_epa) begin
                    acc_reg <= acc_reg + ACC_W'(wdiff);
                end
            end
            ST_ACCUM: acc_reg <= acc_reg + ACC_W'(prod_reg);
            ST_DIV_START: begin
                m_data_reg.bandwidth_index <= k_reg;
                m_data_reg.kernel_sum      <= '0;
                m_data_reg.last_result     <= last_bw;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    m_data_reg.kernel_sum <= sum_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== verif/kernel_density_multi_bandwidth_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_density_multi_bandwidth_tb
// Self-checking bench for the multi-bandwidth kernel density block.
// ----------------------------------------------------------------------------
// Distance items are driven on the s_ channel and the per-bandwidth sums
// are checked on the m_ channel against an exact rational predictor held
// in the bench. Directed tests cover every kernel, the extremes of the
// bandwidth registers and of the distance field, an overfull store and a
// long receiver stall; random cells also run under three idling schemes.
// ----------------------------------------------------------------------------
module kernel_density_multi_bandwidth_tb;
    import kdmb_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_DISTANCES;
    localparam int BW_LIMIT    = DEF_MAX_BANDWIDTHS;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;

    // Shadow of the block's registers and of the current cell's distances.
    logic [1:0]  kernel_mode;
    logic [2:0]  bw_in_use;
    logic [15:0] bw_value [NUM_BW_REGS];
    logic [15:0] cell_dists [$];

    // Sums still owed by the block, oldest first.
    out_item_t   pending_sums [$];

    int          error_count = 0;
    int          snd_idle    = 0;
    int          rcv_idle    = 0;
    int          hold_left   = 0;

    kernel_density_multi_bandwidth DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Exact kernel sum for one bandwidth over the current cell. The weighted
    // sum is kept as an integer numerator over the kernel's normalizer, then
    // rounded half up into Q11.16 and saturated at 27 bits.
    function automatic logic [SUM_W-1:0] density_sum(input logic [15:0] bw);
        logic [127:0] acc;
        logic [127:0] den;
        logic [127:0] b2;
        logic [127:0] d;
        logic [127:0] w;
        logic [127:0] quo;
        int           hits;
        acc  = '0;
        hits = 0;
        b2   = 128'(bw) * 128'(bw);
        foreach (cell_dists[i]) begin
            d = 128'(cell_dists[i]);
            if (d < 128'(bw)) begin
                hits++;
                if (kernel_mode == KERNEL_TRIANGULAR) begin
                    w = 128'(bw) - d;
                end else begin
                    w = b2 - d * d;
                    // Codes 2 and 3 both select the quartic kernel.
                    if (kernel_mode != KERNEL_EPANECHNIKOV) w = w * w;
                end
                acc += w;
            end
        end
        if (hits == 0) return '0;
        if (kernel_mode == KERNEL_TRIANGULAR)
            den = 128'(bw);
        else if (kernel_mode == KERNEL_EPANECHNIKOV)
            den = b2;
        else
            den = b2 * b2;
        acc = (acc << 16) + (den >> 1);
        quo = acc / den;
        if (quo > 128'(SUM_MAX)) return SUM_MAX;
        return quo[SUM_W-1:0];
    endfunction

    // Advances the shadow state by one accepted item and queues the sums
    // that an end-of-cell item releases.
    task automatic absorb_item(input in_item_t it);
        int        cnt;
        out_item_t r;
        if (it.has_distance && cell_dists.size() < STORE_DEPTH)
            cell_dists = {cell_dists, it.distance};
        if (it.end_of_cell) begin
            cnt = bw_in_use;
            if (cnt < 1) cnt = 1;
            if (cnt > BW_LIMIT) cnt = BW_LIMIT;
            for (int k = 0; k < cnt; k++) begin
                r.bandwidth_index = 3'(k);
                r.kernel_sum      = density_sum(bw_value[k]);
                r.last_result     = (k == cnt - 1);
                pending_sums = {pending_sums, r};
            end
            cell_dists.delete();
        end
    endtask

    task automatic send_item(input in_item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        absorb_item(it);
    endtask

    task automatic send_dist(input logic [15:0] dist_val, input bit has, input bit eoc);
        in_item_t it;
        it.distance     = dist_val;
        it.has_distance = has;
        it.end_of_cell  = eoc;
        send_item(it);
    endtask

    // Waits until every owed sum has come back, then lets the block settle.
    task automatic drain;
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // APB write: setup phase, then access phase; the shadow follows.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_KERNEL_SELECT)
            kernel_mode = val[1:0];
        else if (idx == REG_BANDWIDTH_COUNT)
            bw_in_use = val[2:0];
        else
            bw_value[idx - REG_BANDWIDTH_A] = val[15:0];
    endtask

    task automatic set_bandwidths(input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c, input logic [15:0] d,
                                  input logic [15:0] e, input logic [15:0] f);
        reg_write(REG_BANDWIDTH_A,        32'(a));
        reg_write(REG_BANDWIDTH_A + 3'd1, 32'(b));
        reg_write(REG_BANDWIDTH_A + 3'd2, 32'(c));
        reg_write(REG_BANDWIDTH_A + 3'd3, 32'(d));
        reg_write(REG_BANDWIDTH_A + 3'd4, 32'(e));
        reg_write(REG_BANDWIDTH_A + 3'd5, 32'(f));
    endtask

    // Picks a bandwidth, leaning on the edges of the register's range.
    function automatic logic [15:0] pick_bw();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;
            3, 4:    return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Picks a distance: often just around one of the six bandwidth registers so
    // that the strict "below" comparison is exercised on both sides.
    function automatic logic [15:0] pick_dist();
        logic [15:0] b;
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3, 4: begin
                b = bw_value[$urandom_range(0, NUM_BW_REGS - 1)];
                return b + 16'($urandom_range(0, 4)) - 16'd2;
            end
            5, 6: return 16'($urandom_range(0, 511));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config;
        reg_write(REG_KERNEL_SELECT, 32'($urandom_range(0, 3)));
        reg_write(REG_BANDWIDTH_COUNT, 32'($urandom_range(0, 7)));
        set_bandwidths(pick_bw(), pick_bw(), pick_bw(), pick_bw(), pick_bw(), pick_bw());
    endtask

    // One cell of the given length; the end item carries a distance or not.
    task automatic random_cell(input int len);
        for (int i = 0; i < len; i++)
            send_dist(pick_dist(), $urandom_range(0, 99) < 88, 1'b0);
        send_dist(pick_dist(), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: triangular kernel, one bandwidth of 1.0. An empty cell
    // gives a zero sum, and an end item with a distance counts that distance.
    task automatic test_reset_defaults;
        send_dist(16'd0, 1'b0, 1'b1);
        send_dist(16'd128, 1'b1, 1'b1);
        send_dist(16'd0, 1'b1, 1'b0);
        send_dist(16'd256, 1'b1, 1'b0);
        send_dist(16'hFFFF, 1'b1, 1'b1);
        drain();
    endtask

    // Every kernel code, including both codes that decode as quartic, on the
    // same cell at all six bandwidths, zero and full scale among them.
    task automatic test_kernels;
        reg_write(REG_BANDWIDTH_COUNT, 32'd6);
        set_bandwidths(16'd0, 16'd1, 16'd256, 16'd700, 16'hFFFE, 16'hFFFF);
        for (int k = 0; k < 4; k++) begin
            reg_write(REG_KERNEL_SELECT, 32'(k));
            send_dist(16'd0, 1'b1, 1'b0);
            send_dist(16'd1, 1'b1, 1'b0);
            send_dist(16'd255, 1'b1, 1'b0);
            send_dist(16'd699, 1'b1, 1'b0);
            send_dist(16'hFFFE, 1'b1, 1'b0);
            send_dist(16'h1234, 1'b0, 1'b1);
            drain();
        end
    endtask

    // A bandwidth count of zero acts as one, and seven as six.
    task automatic test_count_limits;
        reg_write(REG_KERNEL_SELECT, 32'(KERNEL_EPANECHNIKOV));
        reg_write(REG_BANDWIDTH_COUNT, 32'd0);
        send_dist(16'd10, 1'b1, 1'b1);
        drain();
        reg_write(REG_BANDWIDTH_COUNT, 32'd7);
        send_dist(16'd10, 1'b1, 1'b0);
        send_dist(16'd300, 1'b1, 1'b1);
        drain();
    endtask

    // More distances than the store holds: the surplus is dropped. The
    // distances that fit sit at zero so every sum is as large as it can get.
    task automatic test_store_full;
        reg_write(REG_KERNEL_SELECT, 32'd2);
        reg_write(REG_BANDWIDTH_COUNT, 32'd6);
        set_bandwidths(16'd1, 16'd2, 16'd300, 16'd4000, 16'h8000, 16'hFFFF);
        for (int i = 0; i < STORE_DEPTH + 8; i++)
            send_dist((i < STORE_DEPTH) ? 16'd0 : 16'd1, 1'b1, 1'b0);
        send_dist(16'd0, 1'b1, 1'b1);
        drain();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // cells, so the block sits in its output state and holds off its input.
    task automatic test_backpressure;
        reg_write(REG_BANDWIDTH_COUNT, 32'd6);
        @(posedge aclk);
        hold_left = 2000;
        for (int c = 0; c < 4; c++)
            random_cell($urandom_range(3, 10));
        drain();
    endtask

    // Random cells under the given idling, reconfiguring between groups.
    task automatic test_random_cells(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            random_config();
            for (int c = 0; c < 4 && sent < items; c++) begin
                automatic int len = ($urandom_range(0, 9) == 0) ?
                                    $urandom_range(20, 60) : $urandom_range(0, 8);
                random_cell(len);
                sent += len + 1;
            end
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver ready: random idling, overridden by a counted hold-off.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // Every accepted sum is compared with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result idx=%0d sum=%0d last=%0b", $time,
                         m_data.bandwidth_index, m_data.kernel_sum, m_data.last_result);
                error_count++;
            end else begin
                automatic out_item_t want = pending_sums.pop_front();
                if (m_data.bandwidth_index !== want.bandwidth_index) begin
                    $display("%0t: bandwidth_index expected %0d got %0d", $time,
                             want.bandwidth_index, m_data.bandwidth_index);
                    error_count++;
                end
                if (m_data.kernel_sum !== want.kernel_sum) begin
                    $display("%0t: kernel_sum (idx %0d) expected %0d got %0d", $time,
                             want.bandwidth_index, want.kernel_sum, m_data.kernel_sum);
                    error_count++;
                end
                if (m_data.last_result !== want.last_result) begin
                    $display("%0t: last_result expected %0b got %0b", $time,
                             want.last_result, m_data.last_result);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        kernel_mode = 2'd0;
        bw_in_use   = 3'd1;
        for (int i = 0; i < NUM_BW_REGS; i++) bw_value[i] = 16'd256;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (3) @(posedge aclk);

        test_reset_defaults();
        test_kernels();
        test_count_limits();
        test_store_full();

        // Three idling schemes for the random part.
        snd_idle = 27;
        rcv_idle = 57;
        test_random_cells(125);
        snd_idle = 57;
        rcv_idle = 27;
        test_random_cells(125);
        snd_idle = 0;
        rcv_idle = 0;
        test_random_cells(120);
        test_backpressure();

        // The last drain already waited out the block's final cycles.
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== kernel_density_multi_bandwidth.f =====
sv/kdmb_pkg.sv
sv/kdmb_ram.sv
sv/kdmb_div.sv
sv/kernel_density_multi_bandwidth.sv
verif/kernel_density_multi_bandwidth_tb.sv
